@@ rtl/core/segment_intersection_test_assert.svh @@
// ----------------------------------------------------------------------------
// segment_intersection_test assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_ASSERT_SVH

// Same-cycle implication.
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ rtl/core/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Widths, types and constants shared by the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int EPS_W   = 16;

	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(16);

	// Box flags, one per endpoint-against-segment test.
	localparam int BOX_A_CD = 0;
	localparam int BOX_B_CD = 1;
	localparam int BOX_C_AB = 2;
	localparam int BOX_D_AB = 3;
	localparam int BOX_N    = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic [EPS_W-1:0]          eps_t;
	typedef logic [BOX_N-1:0]          box_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} vec_t;

	typedef struct packed {
		prod_t x;
		prod_t y;
		prod_t z;
	} normal_t;

	// zero: collinear; neg: negative orientation (forced low when zero).
	typedef struct packed {
		logic zero;
		logic neg;
	} orient_t;

endpackage

@@ rtl/core/segment_intersection_test.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_test
// Streaming test of whether 3D segments AB and CD (signed Q8.8) intersect.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             beat payload
//   -------  ---------  --------------------  ---------------------------------
//   in       sink       in_valid / in_stall   a_x..d_z, twelve Q8.8 coordinates
//   out      source     out_valid / out_stall segments_cross
//   cfg      sink       cfg_valid / cfg_ready epsilon (Q0.16 tolerance)
//
// One beat enters per cycle while in_stall is low; the result is registered
// through differences, products, normals, orientations and output.
// The four cross products use six 17x17 multipliers each, with registered products.
// Reset clears every valid bit and loads epsilon with 16.
// A stalled output freezes the whole pipeline; in_stall follows it only while
// the output register is full, so no beat is dropped or repeated.
// ----------------------------------------------------------------------------
`include "segment_intersection_test_assert.svh"

module segment_intersection_test (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  sit_pkg::coord_t a_x, a_y, a_z,
	input  sit_pkg::coord_t b_x, b_y, b_z,
	input  sit_pkg::coord_t c_x, c_y, c_z,
	input  sit_pkg::coord_t d_x, d_y, d_z,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            segments_cross,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  sit_pkg::eps_t   epsilon
);
	import sit_pkg::*;

	logic    adv;
	eps_t    epsilon_q;
	logic    v_s1, v_s2, v_s3, v_s4;
	box_t    box_s1, box_s2, box_s3, box_s4;
	vec_t    u_cd_s1, v_ca_s1, v_cb_s1, u_ab_s1, v_ac_s1, v_ad_s1;
	normal_t n_a_s3, n_b_s3, n_c_s3, n_d_s3;
	orient_t o_a, o_b, o_c, o_d;
	orient_t oa_s4, ob_s4, oc_s4, od_s4;
	logic    hit;

	// Advance everything whenever the output register can take a new beat.
	assign adv       = !out_valid || !out_stall;
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= EPS_RESET;
		end else if (cfg_valid) begin
			epsilon_q <= epsilon;
		end
	end

	// Stage 1: offsets and box tests.
	sit_diff u_diff (
		.clk     (clk),
		.en      (adv),
		.a_x     (a_x), .a_y(a_y), .a_z(a_z),
		.b_x     (b_x), .b_y(b_y), .b_z(b_z),
		.c_x     (c_x), .c_y(c_y), .c_z(c_z),
		.d_x     (d_x), .d_y(d_y), .d_z(d_z),
		.u_cd_s1 (u_cd_s1),
		.v_ca_s1 (v_ca_s1),
		.v_cb_s1 (v_cb_s1),
		.u_ab_s1 (u_ab_s1),
		.v_ac_s1 (v_ac_s1),
		.v_ad_s1 (v_ad_s1),
		.box_s1  (box_s1)
	);

	// Stages 2 and 3: one cross product unit per orientation test.
	sit_cross u_cross_a (.clk(clk), .en(adv), .u(u_cd_s1), .v(v_ca_s1), .n_s3(n_a_s3));
	sit_cross u_cross_b (.clk(clk), .en(adv), .u(u_cd_s1), .v(v_cb_s1), .n_s3(n_b_s3));
	sit_cross u_cross_c (.clk(clk), .en(adv), .u(u_ab_s1), .v(v_ac_s1), .n_s3(n_c_s3));
	sit_cross u_cross_d (.clk(clk), .en(adv), .u(u_ab_s1), .v(v_ad_s1), .n_s3(n_d_s3));

	// Stage 4 input: classify each normal.
	sit_orient u_orient_a (.n(n_a_s3), .eps(epsilon_q), .o(o_a));
	sit_orient u_orient_b (.n(n_b_s3), .eps(epsilon_q), .o(o_b));
	sit_orient u_orient_c (.n(n_c_s3), .eps(epsilon_q), .o(o_c));
	sit_orient u_orient_d (.n(n_d_s3), .eps(epsilon_q), .o(o_d));

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	// Box flags ride alongside the arithmetic; orientations latch in stage 4.
	always_ff @(posedge clk) begin
		if (adv) begin
			box_s2 <= box_s1;
			box_s3 <= box_s2;
			box_s4 <= box_s3;
			oa_s4  <= o_a;
			ob_s4  <= o_b;
			oc_s4  <= o_c;
			od_s4  <= o_d;
		end
	end

	// Proper crossing, or a collinear endpoint inside the other box.
	always_comb begin
		hit = ((oa_s4 != ob_s4) && (oc_s4 != od_s4))
			|| (oa_s4.zero && box_s4[BOX_A_CD])
			|| (ob_s4.zero && box_s4[BOX_B_CD])
			|| (oc_s4.zero && box_s4[BOX_C_AB])
			|| (od_s4.zero && box_s4[BOX_D_AB]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			segments_cross <= hit;
		end
	end

	`SIT_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall, "input stalled while output free")
	`SIT_ASSERT_NEXT(a_s4_to_out, adv && v_s4, out_valid, "stage 4 beat lost")
	`SIT_ASSERT_NEXT(a_no_invented, adv && !v_s4, !out_valid, "output beat invented")
	`SIT_ASSERT_NEXT(a_eps_write, cfg_valid, epsilon_q == $past(epsilon), "epsilon write missed")

endmodule

@@ rtl/core/sit_diff.sv @@
// ----------------------------------------------------------------------------
// sit_diff
// Stage 1: direction and offset vectors plus the four bounding box tests.
// ----------------------------------------------------------------------------
module sit_diff (
	input  logic            clk,
	input  logic            en,
	input  sit_pkg::coord_t a_x, a_y, a_z,
	input  sit_pkg::coord_t b_x, b_y, b_z,
	input  sit_pkg::coord_t c_x, c_y, c_z,
	input  sit_pkg::coord_t d_x, d_y, d_z,
	output sit_pkg::vec_t   u_cd_s1,
	output sit_pkg::vec_t   v_ca_s1,
	output sit_pkg::vec_t   v_cb_s1,
	output sit_pkg::vec_t   u_ab_s1,
	output sit_pkg::vec_t   v_ac_s1,
	output sit_pkg::vec_t   v_ad_s1,
	output sit_pkg::box_t   box_s1
);
	import sit_pkg::*;

	function automatic diff_t sub(input coord_t m, input coord_t p);
		sub = {m[COORD_W-1], m} - {p[COORD_W-1], p};
	endfunction

	function automatic logic in_rng(input coord_t v, input coord_t e0, input coord_t e1);
		coord_t lo;
		coord_t hi;
		lo = (e0 < e1) ? e0 : e1;
		hi = (e0 < e1) ? e1 : e0;
		in_rng = (v >= lo) && (v <= hi);
	endfunction

	box_t box_d;

	always_comb begin
		box_d[BOX_A_CD] = in_rng(a_x, c_x, d_x) && in_rng(a_y, c_y, d_y)
			&& in_rng(a_z, c_z, d_z);
		box_d[BOX_B_CD] = in_rng(b_x, c_x, d_x) && in_rng(b_y, c_y, d_y)
			&& in_rng(b_z, c_z, d_z);
		box_d[BOX_C_AB] = in_rng(c_x, a_x, b_x) && in_rng(c_y, a_y, b_y)
			&& in_rng(c_z, a_z, b_z);
		box_d[BOX_D_AB] = in_rng(d_x, a_x, b_x) && in_rng(d_y, a_y, b_y)
			&& in_rng(d_z, a_z, b_z);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_cd_s1 <= '{sub(d_x, c_x), sub(d_y, c_y), sub(d_z, c_z)};
			v_ca_s1 <= '{sub(a_x, c_x), sub(a_y, c_y), sub(a_z, c_z)};
			v_cb_s1 <= '{sub(b_x, c_x), sub(b_y, c_y), sub(b_z, c_z)};
			u_ab_s1 <= '{sub(b_x, a_x), sub(b_y, a_y), sub(b_z, a_z)};
			v_ac_s1 <= '{sub(c_x, a_x), sub(c_y, a_y), sub(c_z, a_z)};
			v_ad_s1 <= '{sub(d_x, a_x), sub(d_y, a_y), sub(d_z, a_z)};
			box_s1  <= box_d;
		end
	end

endmodule

@@ rtl/core/sit_cross.sv @@
// ----------------------------------------------------------------------------
// sit_cross
// Stages 2 and 3: exact cross product u x v, products then differences.
// ----------------------------------------------------------------------------
module sit_cross (
	input  logic             clk,
	input  logic             en,
	input  sit_pkg::vec_t    u,
	input  sit_pkg::vec_t    v,
	output sit_pkg::normal_t n_s3
);
	import sit_pkg::*;

	prod_t p_yz_s2, p_zy_s2, p_zx_s2, p_xz_s2, p_xy_s2, p_yx_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p_yz_s2 <= $signed(u.y) * $signed(v.z);
			p_zy_s2 <= $signed(u.z) * $signed(v.y);
			p_zx_s2 <= $signed(u.z) * $signed(v.x);
			p_xz_s2 <= $signed(u.x) * $signed(v.z);
			p_xy_s2 <= $signed(u.x) * $signed(v.y);
			p_yx_s2 <= $signed(u.y) * $signed(v.x);
		end
	end

	// Products stay below 2^32 in magnitude, so the differences fit exactly.
	always_ff @(posedge clk) begin
		if (en) begin
			n_s3.x <= p_yz_s2 - p_zy_s2;
			n_s3.y <= p_zx_s2 - p_xz_s2;
			n_s3.z <= p_xy_s2 - p_yx_s2;
		end
	end

endmodule

@@ rtl/core/sit_orient.sv @@
// ----------------------------------------------------------------------------
// sit_orient
// Classify a normal as collinear, positive or negative against epsilon.
// ----------------------------------------------------------------------------
module sit_orient (
	input  sit_pkg::normal_t n,
	input  sit_pkg::eps_t    eps,
	output sit_pkg::orient_t o
);
	import sit_pkg::*;

	function automatic logic near0(input prod_t c, input eps_t e);
		logic [PROD_W-1:0] m;
		m = c[PROD_W-1] ? PROD_W'(-c) : PROD_W'(c);
		near0 = (m <= PROD_W'(e));
	endfunction

	logic zx, zy, zz;

	always_comb begin
		zx = near0(n.x, eps);
		zy = near0(n.y, eps);
		zz = near0(n.z, eps);
		o.zero = zx && zy && zz;
		// Fall back from z to y to x while the component is negligible.
		if (o.zero) begin
			o.neg = 1'b0;
		end else if (!zz) begin
			o.neg = n.z[PROD_W-1];
		end else if (!zy) begin
			o.neg = n.y[PROD_W-1];
		end else begin
			o.neg = n.x[PROD_W-1];
		end
	end

endmodule
